/* rtl/zgfp_pkg.sv */
`default_nettype none

package zgfp_pkg;

    typedef enum logic [2:0] {
        PH_IDLE       = 3'd0,
        PH_GREET      = 3'd1,
        PH_WANT_READY = 3'd2,
        PH_FLAGS      = 3'd3,
        PH_LENGTH     = 3'd4,
        PH_BODY       = 3'd5
    } phase_t;

    typedef enum logic [3:0] {
        EV_MORE          = 4'd0,
        EV_SEND_GREETING = 4'd1,
        EV_SEND_READY    = 4'd2,
        EV_HEADER        = 4'd3,
        EV_BODY          = 4'd4,
        EV_FRAME         = 4'd5,
        EV_MESSAGE       = 4'd6,
        EV_PEER_READY    = 4'd7,
        EV_NOT_CONNECTED = 4'd8,
        EV_BUSY          = 4'd9,
        EV_VERSION       = 4'd10,
        EV_OVERFLOW      = 4'd11,
        EV_PROTOCOL      = 4'd12
    } event_t;

    typedef enum logic {
        OP_BYTE    = 1'b0,
        OP_CONNECT = 1'b1
    } opcode_t;

    // flags byte bits
    localparam int FL_MORE    = 0;
    localparam int FL_LONG    = 1;
    localparam int FL_COMMAND = 2;

    localparam logic [7:0] SIG_FIRST     = 8'hFF;
    localparam logic [7:0] SIG_LAST      = 8'h7F;
    localparam logic [7:0] MIN_MAJOR     = 8'd3;
    localparam logic [5:0] GREETING_LAST = 6'd63;
    localparam logic [2:0] LONG_LEN_LAST = 3'd7;
    localparam int         READY_LEN     = 6;
    localparam logic [7:0] FRAMES_RESET  = 8'd16;

    // configuration port
    localparam int   CFG_ADDR_BITS  = 3;
    localparam logic REG_MAX_FRAMES = 1'b0;

    // expected byte of the "\x05READY" command body
    function automatic logic [7:0] ready_byte(input logic [2:0] idx);
        logic [7:0] b;
        case (idx)
            3'd0:    b = 8'h05;
            3'd1:    b = "R";
            3'd2:    b = "E";
            3'd3:    b = "A";
            3'd4:    b = "D";
            3'd5:    b = "Y";
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    // check of one NULL-mechanism greeting byte at its offset
    function automatic logic greeting_ok(input logic [5:0] pos, input logic [7:0] b);
        logic ok;
        if (pos == 6'd0)
            ok = (b == SIG_FIRST);
        else if (pos <= 6'd8)
            ok = 1'b1;
        else if (pos == 6'd9)
            ok = (b == SIG_LAST);
        else if (pos == 6'd10)
            ok = (b >= MIN_MAJOR);
        else if (pos == 6'd11)
            ok = 1'b1;
        else if (pos == 6'd12)
            ok = (b == "N");
        else if (pos == 6'd13)
            ok = (b == "U");
        else if (pos == 6'd14 || pos == 6'd15)
            ok = (b == "L");
        else
            ok = (b == 8'h00);
        return ok;
    endfunction

endpackage

`default_nettype wire

/* rtl/zgfp_apb.sv */
`default_nettype none

module zgfp_apb
    import zgfp_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     psel,
    input  wire logic                     penable,
    input  wire logic                     pwrite,
    input  wire logic [CFG_ADDR_BITS-1:0] paddr,
    input  wire logic [31:0]              pwdata,
    output logic      [31:0]              prdata,
    output logic                          pready,
    output logic      [7:0]               max_frames
);

    logic [7:0] max_frames_reg;
    logic       hit;

    // word index sits above the byte offset
    assign hit = (paddr[CFG_ADDR_BITS-1] == REG_MAX_FRAMES) && (paddr[1:0] == 2'b00
                 || paddr[1:0] != 2'b00);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_frames_reg <= FRAMES_RESET;
        end
        else if (psel && penable && pwrite && hit)
        begin
            max_frames_reg <= pwdata[7:0];
        end
    end

    assign prdata     = hit ? {24'd0, max_frames_reg} : 32'd0;
    assign pready     = 1'b1;
    assign max_frames = max_frames_reg;

endmodule

`default_nettype wire

/* rtl/zmtp_greeting_and_frame_parser_core.sv */
`default_nettype none

// Channel  | Handshake             | Payload
// ---------+-----------------------+------------------------------------------
// in       | in_valid / in_ready   | opcode, byte_in
// out      | out_valid / out_ready | event_res, data_byte, frame_index,
//          |                       | frame_flags, frame_length, message_frames,
//          |                       | peer_ready, link_phase
// config   | APB (psel, penable)   | max_frames at byte address 0
//
// One item per cycle unless out_ready stalls: the parser state and the result
// register update at the edge that accepts it, so the result shows next cycle.
// The longest path is the LENGTH_BITS-wide body position compare.
// rst_n clears the parser state asynchronously; max_frames returns to 16.
// in_ready is high while the result slot is empty or being taken this cycle.

module zmtp_greeting_and_frame_parser_core
    import zgfp_pkg::*;
#(
    parameter int LENGTH_BITS = 64
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,

    input  wire logic                     in_valid,
    output logic                          in_ready,
    input  wire logic [0:0]               opcode,
    input  wire logic [7:0]               byte_in,

    output logic                          out_valid,
    input  wire logic                     out_ready,
    output logic      [3:0]               event_res,
    output logic      [7:0]               data_byte,
    output logic      [7:0]               frame_index,
    output logic      [7:0]               frame_flags,
    output logic      [63:0]              frame_length,
    output logic      [7:0]               message_frames,
    output logic      [0:0]               peer_ready,
    output logic      [2:0]               link_phase,

    input  wire logic                     psel,
    input  wire logic                     penable,
    input  wire logic                     pwrite,
    input  wire logic [CFG_ADDR_BITS-1:0] paddr,
    input  wire logic [31:0]              pwdata,
    output logic      [31:0]              prdata,
    output logic                          pready
);

    logic [7:0] max_frames;

    zgfp_apb u_apb (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .max_frames (max_frames)
    );

    phase_t                 phase_reg,         phase_next;
    logic [LENGTH_BITS-1:0] position_reg,      position_next;
    logic [LENGTH_BITS-1:0] length_accum_reg,  length_accum_next;
    logic [7:0]             flags_held_reg,    flags_held_next;
    logic [7:0]             frame_counter_reg, frame_counter_next;
    logic                   ready_flag_reg,    ready_flag_next;
    logic                   command_match_reg, command_match_next;
    logic [7:0]             last_count_reg,    last_count_next;
    event_t                 event_reg,         event_next;
    logic [7:0]             data_reg,          data_next;
    logic                   out_valid_reg;

    logic                   accept;
    logic                   is_connect;
    logic                   greet_ok;
    logic                   greet_last;
    logic                   len_long;
    logic                   len_last;
    logic [LENGTH_BITS-1:0] len_value;
    logic                   len_zero;
    logic [LENGTH_BITS-1:0] pos_inc;
    logic                   body_last;
    logic                   match_now;
    logic                   is_command;
    logic                   cmd_ok;
    logic                   room;
    logic [7:0]             count_inc;
    phase_t                 done_phase;

    assign in_ready   = !out_valid_reg || out_ready;
    assign accept     = in_valid && in_ready;
    assign is_connect = (opcode_t'(opcode) == OP_CONNECT);

    assign greet_ok   = greeting_ok(position_reg[5:0], byte_in);
    assign greet_last = (position_reg[5:0] == GREETING_LAST);

    assign len_long  = flags_held_reg[FL_LONG];
    assign len_value = len_long ? ((length_accum_reg << 8) | LENGTH_BITS'(byte_in))
                                : LENGTH_BITS'(byte_in);
    assign len_last  = !len_long || (position_reg[2:0] == LONG_LEN_LAST);
    assign len_zero  = (len_value == '0);

    assign pos_inc   = position_reg + LENGTH_BITS'(1);
    assign body_last = (pos_inc >= length_accum_reg);

    // a mismatch among the first six body bytes spoils the READY command
    assign match_now = command_match_reg
                       && !((position_reg < LENGTH_BITS'(READY_LEN))
                            && (byte_in != ready_byte(position_reg[2:0])));

    assign is_command = flags_held_reg[FL_COMMAND];
    // zero-length frames complete from the length phase and never qualify
    assign cmd_ok     = (phase_reg == PH_BODY)
                        && (length_accum_reg >= LENGTH_BITS'(READY_LEN)) && match_now;
    assign room       = (frame_counter_reg < max_frames);
    assign count_inc  = frame_counter_reg + 8'd1;
    assign done_phase = (is_command && !cmd_ok) ? PH_IDLE : PH_FLAGS;

    // next phase
    always_comb
    begin
        phase_next = phase_reg;
        if (is_connect)
        begin
            if (phase_reg == PH_IDLE)
                phase_next = PH_GREET;
        end
        else
        begin
            unique case (phase_reg)
                PH_GREET:
                begin
                    if (!greet_ok)
                        phase_next = PH_IDLE;
                    else if (greet_last)
                        phase_next = PH_WANT_READY;
                end
                PH_WANT_READY, PH_FLAGS:
                begin
                    if (room)
                        phase_next = PH_LENGTH;
                end
                PH_LENGTH:
                begin
                    if (len_last)
                        phase_next = len_zero ? done_phase : PH_BODY;
                end
                PH_BODY:
                begin
                    if (body_last)
                        phase_next = done_phase;
                end
                default:
                begin
                    phase_next = phase_reg;
                end
            endcase
        end
    end

    // datapath and event
    always_comb
    begin
        position_next      = position_reg;
        length_accum_next  = length_accum_reg;
        flags_held_next    = flags_held_reg;
        frame_counter_next = frame_counter_reg;
        ready_flag_next    = ready_flag_reg;
        command_match_next = command_match_reg;
        last_count_next    = last_count_reg;
        event_next         = EV_MORE;
        data_next          = 8'd0;

        if (is_connect)
        begin
            if (phase_reg == PH_IDLE)
            begin
                position_next = '0;
                event_next    = EV_SEND_GREETING;
            end
            else
            begin
                event_next = EV_BUSY;
            end
        end
        else
        begin
            unique case (phase_reg)
                PH_GREET:
                begin
                    if (!greet_ok)
                    begin
                        ready_flag_next   = 1'b0;
                        position_next     = '0;
                        length_accum_next = '0;
                        event_next        = EV_VERSION;
                    end
                    else if (greet_last)
                    begin
                        position_next = '0;
                        event_next    = EV_SEND_READY;
                    end
                    else
                    begin
                        position_next = pos_inc;
                    end
                end
                PH_WANT_READY, PH_FLAGS:
                begin
                    if (room)
                    begin
                        flags_held_next    = byte_in;
                        command_match_next = 1'b1;
                        length_accum_next  = '0;
                        position_next      = '0;
                    end
                    else
                    begin
                        event_next = EV_OVERFLOW;
                    end
                end
                PH_LENGTH, PH_BODY:
                begin
                    if (phase_reg == PH_LENGTH)
                    begin
                        length_accum_next = len_value;
                        position_next     = len_last ? '0 : pos_inc;
                        event_next        = len_last ? EV_HEADER : EV_MORE;
                    end
                    else
                    begin
                        data_next          = byte_in;
                        command_match_next = match_now;
                        position_next      = pos_inc;
                        event_next         = EV_BODY;
                    end

                    // frame completion
                    if ((phase_reg == PH_LENGTH && len_last && len_zero)
                        || (phase_reg == PH_BODY && body_last))
                    begin
                        position_next = '0;
                        if (is_command)
                        begin
                            if (cmd_ok)
                            begin
                                ready_flag_next = 1'b1;
                                event_next      = EV_PEER_READY;
                            end
                            else
                            begin
                                ready_flag_next   = 1'b0;
                                length_accum_next = '0;
                                event_next        = EV_PROTOCOL;
                            end
                        end
                        else if (flags_held_reg[FL_MORE])
                        begin
                            frame_counter_next = count_inc;
                            event_next         = EV_FRAME;
                        end
                        else
                        begin
                            last_count_next    = count_inc;
                            frame_counter_next = 8'd0;
                            event_next         = EV_MESSAGE;
                        end
                    end
                end
                default:
                begin
                    event_next = EV_NOT_CONNECTED;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= PH_IDLE;
            position_reg      <= '0;
            length_accum_reg  <= '0;
            flags_held_reg    <= 8'd0;
            frame_counter_reg <= 8'd0;
            ready_flag_reg    <= 1'b0;
            command_match_reg <= 1'b1;
            last_count_reg    <= 8'd0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                phase_reg         <= phase_next;
                position_reg      <= position_next;
                length_accum_reg  <= length_accum_next;
                flags_held_reg    <= flags_held_next;
                frame_counter_reg <= frame_counter_next;
                ready_flag_reg    <= ready_flag_next;
                command_match_reg <= command_match_next;
                last_count_reg    <= last_count_next;
                out_valid_reg     <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            event_reg <= event_next;
            data_reg  <= data_next;
        end
    end

    // state only moves on accept, and accept needs the slot free, so the
    // state registers hold the after-step values for the pending item
    assign out_valid      = out_valid_reg;
    assign event_res      = event_reg;
    assign data_byte      = data_reg;
    assign frame_index    = frame_counter_reg;
    assign frame_flags    = flags_held_reg;
    assign frame_length   = 64'(length_accum_reg);
    assign message_frames = last_count_reg;
    assign peer_ready     = ready_flag_reg;
    assign link_phase     = phase_reg;

endmodule

`default_nettype wire

/* tb/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;
    import zgfp_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam logic [CFG_ADDR_BITS-1:0] MAX_FRAMES_ADDR =
        CFG_ADDR_BITS'(4 * int'(REG_MAX_FRAMES));
    localparam logic [31:0] NULL_MECH  = "NULL";
    localparam logic [47:0] READY_BODY = {8'h05, "READY"};

    typedef struct packed {
        logic [7:0]  max_frames;
        phase_t      phase;
        logic [63:0] position;
        logic [63:0] length_accum;
        logic [7:0]  flags_held;
        logic [7:0]  frame_counter;
        logic [7:0]  last_count;
        logic        ready_flag;
        logic        command_match;
    } link_state_t;

    typedef struct packed {
        event_t      ev;
        logic [7:0]  data;
        logic [7:0]  index;
        logic [7:0]  flags;
        logic [63:0] length;
        logic [7:0]  msgs;
        logic        peer;
        phase_t      phase;
    } link_result_t;

    typedef struct packed {
        opcode_t    op;
        logic [7:0] b;
    } rx_item_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [0:0]  opcode = 1'b0;
    logic [7:0]  byte_in = 8'd0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [3:0]  event_res;
    logic [7:0]  data_byte;
    logic [7:0]  frame_index;
    logic [7:0]  frame_flags;
    logic [63:0] frame_length;
    logic [7:0]  message_frames;
    logic [0:0]  peer_ready;
    logic [2:0]  link_phase;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [CFG_ADDR_BITS-1:0] paddr = '0;
    logic [31:0] pwdata = 32'd0;
    logic [31:0] prdata;
    logic        pready;

    rx_item_t     rx_items[$];
    link_result_t link_results_due[$];
    link_state_t  link_now;
    link_state_t  link_plan;
    link_result_t plan_res;
    link_result_t want;
    rx_item_t     next_item;
    logic         in_fire = 1'b0;
    int           send_gap_pct = 0;
    int           recv_stall_pct = 0;
    int           mismatches = 0;
    int           cycle_count = 0;

    zmtp_greeting_and_frame_parser_core i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .opcode         (opcode),
        .byte_in        (byte_in),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .event_res      (event_res),
        .data_byte      (data_byte),
        .frame_index    (frame_index),
        .frame_flags    (frame_flags),
        .frame_length   (frame_length),
        .message_frames (message_frames),
        .peer_ready     (peer_ready),
        .link_phase     (link_phase),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic logic [7:0] null_at(input int pos);
        return NULL_MECH[31 - 8 * (pos - 12) -: 8];
    endfunction

    function automatic logic [7:0] ready_at(input int idx);
        return READY_BODY[47 - 8 * idx -: 8];
    endfunction

    function automatic bit greeting_fits(input int pos, input logic [7:0] b);
        bit ok;
        if (pos == 0)
            ok = (b == SIG_FIRST);
        else if (pos <= 8 || pos == 11)
            ok = 1'b1;
        else if (pos == 9)
            ok = (b == SIG_LAST);
        else if (pos == 10)
            ok = (b >= MIN_MAJOR);
        else if (pos < 16)
            ok = (b == null_at(pos));
        else
            ok = (b == 8'h00);
        return ok;
    endfunction

    function automatic logic [7:0] greeting_fill(input int pos, input logic [7:0] pad,
                                                 input logic [7:0] major);
        logic [7:0] b;
        if (pos == 0)
            b = SIG_FIRST;
        else if (pos <= 8 || pos == 11)
            b = pad;
        else if (pos == 9)
            b = SIG_LAST;
        else if (pos == 10)
            b = major;
        else if (pos < 16)
            b = null_at(pos);
        else
            b = 8'h00;
        return b;
    endfunction

    function automatic link_state_t link_reset_state();
        link_state_t s;
        s = '0;
        s.max_frames = FRAMES_RESET;
        s.phase = PH_IDLE;
        s.command_match = 1'b1;
        return s;
    endfunction

    function automatic void drop_link(inout link_state_t s);
        s.phase = PH_IDLE;
        s.ready_flag = 1'b0;
        s.position = '0;
        s.length_accum = '0;
    endfunction

    function automatic event_t finish_frame(inout link_state_t s);
        event_t ev;
        s.position = '0;
        s.phase = PH_FLAGS;
        if (s.flags_held[FL_COMMAND])
        begin
            if (s.length_accum >= 64'(READY_LEN) && s.command_match)
            begin
                s.ready_flag = 1'b1;
                ev = EV_PEER_READY;
            end
            else
            begin
                drop_link(s);
                ev = EV_PROTOCOL;
            end
        end
        else
        begin
            s.frame_counter = s.frame_counter + 8'd1;
            if (s.flags_held[FL_MORE])
                ev = EV_FRAME;
            else
            begin
                s.last_count = s.frame_counter;
                s.frame_counter = 8'd0;
                ev = EV_MESSAGE;
            end
        end
        return ev;
    endfunction

    function automatic event_t length_complete(inout link_state_t s);
        event_t ev;
        s.position = '0;
        if (s.length_accum == 64'd0)
            ev = finish_frame(s);
        else
        begin
            s.phase = PH_BODY;
            ev = EV_HEADER;
        end
        return ev;
    endfunction

    // one item through the link parser, state updated in place
    function automatic link_result_t advance_link(inout link_state_t s, input opcode_t op,
                                                  input logic [7:0] b);
        link_result_t r;
        event_t ev;
        logic [7:0] data;
        ev = EV_MORE;
        data = 8'd0;
        if (op == OP_CONNECT)
        begin
            if (s.phase == PH_IDLE)
            begin
                s.phase = PH_GREET;
                s.position = '0;
                ev = EV_SEND_GREETING;
            end
            else
                ev = EV_BUSY;
        end
        else
        begin
            case (s.phase)
                PH_GREET:
                begin
                    if (!greeting_fits(int'(s.position[5:0]), b))
                    begin
                        drop_link(s);
                        ev = EV_VERSION;
                    end
                    else if (s.position == 64'd63)
                    begin
                        s.position = '0;
                        s.phase = PH_WANT_READY;
                        ev = EV_SEND_READY;
                    end
                    else
                        s.position = s.position + 64'd1;
                end
                PH_WANT_READY, PH_FLAGS:
                begin
                    if (s.frame_counter < s.max_frames)
                    begin
                        s.flags_held = b;
                        s.command_match = 1'b1;
                        s.length_accum = '0;
                        s.position = '0;
                        s.phase = PH_LENGTH;
                    end
                    else
                        ev = EV_OVERFLOW;
                end
                PH_LENGTH:
                begin
                    if (s.flags_held[FL_LONG])
                    begin
                        s.length_accum = {s.length_accum[55:0], b};
                        s.position = s.position + 64'd1;
                        if (s.position >= 64'd8)
                            ev = length_complete(s);
                    end
                    else
                    begin
                        s.length_accum = {56'd0, b};
                        ev = length_complete(s);
                    end
                end
                PH_BODY:
                begin
                    data = b;
                    if (s.position < 64'(READY_LEN) && b != ready_at(int'(s.position[2:0])))
                        s.command_match = 1'b0;
                    s.position = s.position + 64'd1;
                    if (s.position >= s.length_accum)
                        ev = finish_frame(s);
                    else
                        ev = EV_BODY;
                end
                default:
                    ev = EV_NOT_CONNECTED;
            endcase
        end
        r.ev = ev;
        r.data = data;
        r.index = s.frame_counter;
        r.flags = s.flags_held;
        r.length = s.length_accum;
        r.msgs = s.last_count;
        r.peer = s.ready_flag;
        r.phase = s.phase;
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [63:0] exp_v,
                                        input logic [63:0] got_v);
        if (exp_v !== got_v)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, got_v);
            mismatches++;
        end
    endfunction

    function automatic logic [7:0] pick_length(input bit cmd, input bit noisy);
        logic [7:0] n;
        if (!noisy)
            n = cmd ? 8'(READY_LEN) : 8'd0;
        else if (cmd)
            n = ($urandom_range(4) != 0) ? 8'(READY_LEN) : 8'($urandom_range(12));
        else if ($urandom_range(32) == 0)
            n = 8'($urandom_range(255, 11));
        else
            n = 8'($urandom_range(10));
        return n;
    endfunction

    task automatic send(input opcode_t op, input logic [7:0] b);
        rx_item_t it;
        it.op = op;
        it.b = b;
        rx_items.push_back(it);
        plan_res = advance_link(link_plan, op, b);
    endtask

    task automatic send_greeting(input logic [7:0] pad, input logic [7:0] major);
        for (int p = 0; p < 64; p++)
            send(OP_BYTE, greeting_fill(p, pad, major));
    endtask

    // next item of a plausible session, given where the planned link stands
    task automatic plan_next(input bit noisy);
        logic [7:0] f;
        int pos;
        bit cmd;
        pos = int'(link_plan.position[15:0]);
        cmd = link_plan.flags_held[FL_COMMAND];
        case (link_plan.phase)
            PH_IDLE:
            begin
                if (noisy && $urandom_range(99) < 3)
                    send(OP_BYTE, 8'($urandom));
                else
                    send(OP_CONNECT, 8'($urandom));
            end
            PH_GREET:
            begin
                if (noisy && $urandom_range(199) == 0)
                    send(OP_CONNECT, 8'($urandom));
                else if (noisy && $urandom_range(249) == 0)
                    send(OP_BYTE, 8'($urandom));
                else if (noisy && pos == 10 && $urandom_range(19) == 0)
                    send(OP_BYTE, 8'($urandom_range(2)));
                else
                    send(OP_BYTE, greeting_fill(pos, 8'($urandom),
                                                8'($urandom_range(255, 3))));
            end
            PH_WANT_READY, PH_FLAGS:
            begin
                if (noisy && $urandom_range(49) == 0)
                    send(OP_CONNECT, 8'($urandom));
                else
                begin
                    f = 8'($urandom);
                    f[FL_COMMAND] = noisy && ($urandom_range(99) < 20);
                    f[FL_LONG] = ($urandom_range(3) == 0);
                    // overflow stalls the link for good, so keep messages within max
                    f[FL_MORE] = noisy && ($urandom_range(99) < 60) &&
                                 (int'(link_plan.frame_counter) + 1 <
                                  int'(link_plan.max_frames));
                    send(OP_BYTE, f);
                end
            end
            PH_LENGTH:
            begin
                if (link_plan.flags_held[FL_LONG] && pos < 7)
                    send(OP_BYTE, 8'h00);
                else
                    send(OP_BYTE, pick_length(cmd, noisy));
            end
            PH_BODY:
            begin
                if (noisy && $urandom_range(99) == 0)
                    send(OP_CONNECT, 8'($urandom));
                else if (cmd && pos < READY_LEN && (!noisy || $urandom_range(24) != 0))
                    send(OP_BYTE, ready_at(pos));
                else
                    send(OP_BYTE, 8'($urandom));
            end
            default:
                send(OP_CONNECT, 8'h00);
        endcase
    endtask

    // bring the planned link to a message boundary
    task automatic settle_link();
        while (!((link_plan.phase == PH_FLAGS || link_plan.phase == PH_WANT_READY) &&
                 link_plan.frame_counter == 8'd0))
            plan_next(1'b0);
    endtask

    task automatic drain();
        while (rx_items.size() != 0 || in_valid || link_results_due.size() != 0)
        begin
            @(posedge clk);
            #1;
        end
        repeat (4) @(posedge clk);
    endtask

    task automatic write_max_frames(input logic [7:0] value);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= MAX_FRAMES_ADDR;
        pwdata <= {24'd0, value};
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        link_now.max_frames = value;
        link_plan.max_frames = value;
    endtask

    task automatic random_phase(input logic [7:0] max_frames, input int gap_pct,
                                input int stall_pct, input int n);
        send_gap_pct = gap_pct;
        recv_stall_pct = stall_pct;
        write_max_frames(max_frames);
        repeat (n) plan_next(1'b1);
        settle_link();
    endtask

    // driver
    always @(negedge clk)
    begin
        if (!in_valid || in_fire)
        begin
            if (rx_items.size() != 0 && $urandom_range(99) >= send_gap_pct)
            begin
                next_item = rx_items.pop_front();
                in_valid <= 1'b1;
                opcode <= next_item.op;
                byte_in <= next_item.b;
            end
            else
                in_valid <= 1'b0;
        end
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // monitor and checker
    always @(posedge clk)
    begin
        in_fire <= in_valid && in_ready;
        if (rst_n && out_valid && out_ready)
        begin
            if (link_results_due.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual event %0d",
                         $time, event_res);
                mismatches++;
            end
            else
            begin
                want = link_results_due.pop_front();
                check_field("event_res", want.ev, event_res);
                check_field("data_byte", want.data, data_byte);
                check_field("frame_index", want.index, frame_index);
                check_field("frame_flags", want.flags, frame_flags);
                check_field("frame_length", want.length, frame_length);
                check_field("message_frames", want.msgs, message_frames);
                check_field("peer_ready", want.peer, peer_ready);
                check_field("link_phase", want.phase, link_phase);
            end
        end
        if (rst_n && in_valid && in_ready)
            link_results_due.push_back(advance_link(link_now, opcode_t'(opcode), byte_in));
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    initial
    begin
        link_now = link_reset_state();
        link_plan = link_reset_state();
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: idle byte, connect, busy, failed greetings, frame kinds, overflow
        send_gap_pct = 8;
        recv_stall_pct = 74;
        write_max_frames(8'd2);
        send(OP_BYTE, 8'h00);
        send(OP_CONNECT, 8'hFF);
        send(OP_CONNECT, 8'h00);
        for (int p = 0; p < 11; p++)
            send(OP_BYTE, greeting_fill(p, 8'h00, 8'd2));
        send(OP_CONNECT, 8'h5A);
        send(OP_BYTE, 8'h00);
        send(OP_CONNECT, 8'h00);
        send_greeting(8'hFF, MIN_MAJOR);
        send(OP_BYTE, 8'h04);
        send(OP_BYTE, 8'(READY_LEN));
        for (int i = 0; i < READY_LEN; i++)
            send(OP_BYTE, ready_at(i));
        send(OP_BYTE, 8'h01);
        send(OP_BYTE, 8'h00);
        send(OP_BYTE, 8'h02);
        repeat (7) send(OP_BYTE, 8'h00);
        send(OP_BYTE, 8'h02);
        send(OP_BYTE, 8'hAA);
        send(OP_BYTE, 8'h55);
        // command too short for READY
        send(OP_BYTE, 8'h04);
        send(OP_BYTE, 8'h02);
        send(OP_BYTE, 8'h05);
        send(OP_BYTE, 8'h52);
        send(OP_CONNECT, 8'h00);
        send_greeting(8'h00, 8'hFF);
        send(OP_BYTE, 8'h01);
        send(OP_BYTE, 8'h00);
        send(OP_BYTE, 8'hF9);
        send(OP_BYTE, 8'h00);
        send(OP_BYTE, 8'h00);
        drain();

        random_phase(8'd255, 8, 74, 150);
        drain();
        random_phase(8'd1, 74, 8, 140);
        drain();
        random_phase(FRAMES_RESET, 0, 0, 140);
        // all-ones long length, left open in the body
        send(OP_BYTE, 8'h82);
        repeat (8) send(OP_BYTE, 8'hFF);
        repeat (3) send(OP_BYTE, 8'($urandom));
        drain();

        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

/* files.f */
rtl/zgfp_pkg.sv
rtl/zgfp_apb.sv
rtl/zmtp_greeting_and_frame_parser_core.sv
tb/tb_top.sv
